/* design/assert_macros.svh */
// Assertion macros used by the checker file of the mipmap chain sizer.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tmcs_pkg.sv */
// Package of the mipmap chain sizer: widths, sequencer states, operand struct
// and the bits-per-pixel table. Depends on nothing.
package tmcs_pkg;

    localparam int DIM_BITS     = 15;
    localparam int FORMAT_COUNT = 19;
    localparam int LVL_W        = 5;
    localparam int FMT_W        = 5;
    localparam int BPP_W        = 8;
    localparam int ACC_W        = 32;
    localparam int MUL_B_W      = 16;
    localparam int MUL_FULL_W   = ACC_W + MUL_B_W;
    localparam int BYTE_W       = ACC_W - 3;

    localparam logic [MUL_B_W-1:0] CUBE_FACES = MUL_B_W'(6);

    // Sequencer states: one pass of WH, D, ACC per level, then the format scale.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WH,
        ST_D,
        ST_ACC,
        ST_BPP
    } t_state;

    // Operands of the shared multiplier.
    typedef struct packed {
        logic [ACC_W-1:0]   a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    // Bits per pixel of each format code; unknown codes give zero.
    function automatic logic [BPP_W-1:0] bpp_lookup(input logic [FMT_W-1:0] fmt);
        logic [BPP_W-1:0] bpp;
        case (fmt)
            5'd0, 5'd1, 5'd2:          bpp = 8'h08;
            5'd3, 5'd6, 5'd8, 5'd9:    bpp = 8'h10;
            5'd10, 5'd11:              bpp = 8'h20;
            5'd14:                     bpp = 8'h04;
            5'd15, 5'd16, 5'd17:       bpp = 8'h08;
            5'd18:                     bpp = 8'hFF;
            default:                   bpp = 8'h00;
        endcase
        if (32'(fmt) >= FORMAT_COUNT) begin
            bpp = 8'h00;
        end
        return bpp;
    endfunction

endpackage

/* design/tmcs_mul.sv */
// Shared multiplier of the mipmap chain sizer: low word of a 32 x 16 product.
// Depends on tmcs_pkg.
module tmcs_mul (
    input  tmcs_pkg::t_mul_req          i_req,
    output logic [tmcs_pkg::ACC_W-1:0]  o_prod
);
    import tmcs_pkg::*;

    logic [MUL_FULL_W-1:0] full;

    // Full product, then wrap to the accumulator width.
    assign full   = MUL_FULL_W'(i_req.a) * MUL_FULL_W'(i_req.b);
    assign o_prod = full[ACC_W-1:0];

endmodule

/* design/tmcs_dim.sv */
// Level dimension unit: shifts a base dimension down by the level index,
// clamps to one and optionally trims to a multiple of four. Depends on tmcs_pkg.
module tmcs_dim (
    input  logic [tmcs_pkg::DIM_BITS-1:0] i_base,
    input  logic [tmcs_pkg::LVL_W-1:0]    i_lvl,
    input  logic                          i_trim,
    output logic [tmcs_pkg::DIM_BITS-1:0] o_dim
);
    import tmcs_pkg::*;

    logic [DIM_BITS-1:0] shifted;
    logic [DIM_BITS-1:0] clamped;

    // Halve once per level; anything below two becomes one.
    assign shifted = i_base >> i_lvl;
    assign clamped = (shifted >= DIM_BITS'(2)) ? shifted : DIM_BITS'(1);

    // Block-compressed levels drop the two low bits.
    assign o_dim = i_trim ? (clamped & ~DIM_BITS'(3)) : clamped;

endmodule

/* design/texture_mip_chain_size.sv */
// Mipmap chain sizer top level, built on tmcs_pkg, tmcs_dim and tmcs_mul.
// Operation: after the accepting edge, busy stays high through the WH, D and ACC states
// for each level on the shared multiplier and then the BPP format scale; the byte size
// is then strobed in the first idle cycle. The next start is taken at the edge that
// ends that cycle; no new descriptor is taken while busy.
// Reset (i_rst_n low, synchronous) returns to idle, no strobe; the receiver cannot stall.
module texture_mip_chain_size (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tmcs_pkg::DIM_BITS-1:0] i_tex_width,
    input  logic [tmcs_pkg::DIM_BITS-1:0] i_tex_height,
    input  logic [tmcs_pkg::DIM_BITS-1:0] i_tex_depth,
    input  logic [tmcs_pkg::LVL_W-1:0]    i_level_count,
    input  logic [tmcs_pkg::FMT_W-1:0]    i_pixel_format,
    input  logic                          i_is_compressed,
    input  logic                          i_is_cube,
    output logic                          o_valid,
    output logic [tmcs_pkg::BYTE_W-1:0]   o_byte_size
);
    import tmcs_pkg::*;

    t_state              r_state, n_state;
    logic [DIM_BITS-1:0] r_w, r_h, r_d;
    logic [LVL_W-1:0]    r_count;
    logic [FMT_W-1:0]    r_fmt;
    logic                r_comp, r_cube;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [ACC_W-1:0]    r_prod, n_prod;
    logic [ACC_W-1:0]    r_sum, n_sum;
    logic                r_valid, n_valid;
    logic [BYTE_W-1:0]   r_bytes, n_bytes;

    logic [DIM_BITS-1:0] lw, lh, ld;
    t_mul_req            mul_req;
    logic [ACC_W-1:0]    mul_prod;
    logic                accept;

    assign accept = start && (r_state == ST_IDLE);

    // Dimensions of the current level.
    tmcs_dim u_dim_w (.i_base(r_w), .i_lvl(r_lvl), .i_trim(r_comp), .o_dim(lw));
    tmcs_dim u_dim_h (.i_base(r_h), .i_lvl(r_lvl), .i_trim(r_comp), .o_dim(lh));
    tmcs_dim u_dim_d (.i_base(r_d), .i_lvl(r_lvl), .i_trim(1'b0),   .o_dim(ld));

    // Shared multiplier, its operands picked by the sequencer state.
    tmcs_mul u_mul (.i_req(mul_req), .o_prod(mul_prod));

    // Descriptor capture on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w     <= i_tex_width;
            r_h     <= i_tex_height;
            r_d     <= i_tex_depth;
            r_count <= i_level_count;
            r_fmt   <= i_pixel_format;
            r_comp  <= i_is_compressed;
            r_cube  <= i_is_cube;
        end
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_lvl   <= n_lvl;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_bytes <= n_bytes;
    end

    // Sequencer: next state, multiplier operands and datapath updates.
    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_prod    = r_prod;
        n_sum     = r_sum;
        n_valid   = 1'b0;
        n_bytes   = r_bytes;
        mul_req.a = r_prod;
        mul_req.b = MUL_B_W'(ld);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_lvl   = '0;
                    n_sum   = '0;
                    n_state = (i_level_count == '0) ? ST_BPP : ST_WH;
                end
            end
            ST_WH: begin
                mul_req.a = ACC_W'(lw);
                mul_req.b = MUL_B_W'(lh);
                n_prod    = mul_prod;
                n_state   = ST_D;
            end
            ST_D: begin
                mul_req.a = r_prod;
                mul_req.b = MUL_B_W'(ld);
                n_prod    = mul_prod;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                // Six faces for a cube map, then add the level into the sum.
                mul_req.a = r_prod;
                mul_req.b = CUBE_FACES;
                n_sum     = r_sum + (r_cube ? mul_prod : r_prod);
                n_lvl     = r_lvl + LVL_W'(1);
                n_state   = (r_lvl == r_count - LVL_W'(1)) ? ST_BPP : ST_WH;
            end
            ST_BPP: begin
                // Scale the texel total by bits per pixel and convert to bytes.
                mul_req.a = r_sum;
                mul_req.b = MUL_B_W'(bpp_lookup(r_fmt));
                n_bytes   = mul_prod[ACC_W-1:3];
                n_valid   = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_byte_size = r_bytes;

endmodule

/* design/tmcs_checker.sv */
// Port-level checker of the mipmap chain sizer, bound to the top level.
// Depends on tmcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmcs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [tmcs_pkg::BYTE_W-1:0] o_byte_size
);
    import tmcs_pkg::*;

    // An accepted beat always starts work.
    `ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")

    // A result strobe lasts exactly one cycle.
    `ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "strobe held too long")

    // Results appear only once the work is done.
    `ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result strobed while busy")

    // Finishing an item always delivers its result.
    `ASSERT_IMP(a_done_result, i_clk, i_rst_n, $fell(busy), o_valid, "busy dropped, no result")

    // A strobed byte size is always fully defined.
    `ASSERT_IMP(a_size_known, i_clk, i_rst_n, o_valid, !$isunknown(o_byte_size), "unknown size")

endmodule

bind texture_mip_chain_size tmcs_checker u_tmcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_byte_size (o_byte_size)
);
